/* src/strmm_pkg.sv */
// shared types, constants and helpers for the sparse-table range min/max engine
// no dependencies; imported by the top level, front end, queue and back end
`default_nettype none
package strmm_pkg;

  // table geometry
  localparam int MAX_ENTRIES = 1024;
  localparam int LEVELS      = 11;
  localparam int POS_W       = 10;
  localparam int LVL_W       = 4;
  localparam int CNT_W       = 11;
  localparam int ADDR_W      = LVL_W + POS_W;
  localparam int DEPTH       = LEVELS * MAX_ENTRIES;
  localparam int VAL_W       = 32;

  // command queue between front and back
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = 2;

  // request kinds on the input tuser
  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_BUILD = 2'd1,
    REQ_QUERY = 2'd2
  } req_t;

  // back-end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_QUERY,
    BK_BUILD,
    BK_DRAIN
  } back_state_t;

  // one decoded command in the queue
  typedef struct packed {
    req_t              op;
    logic              bad;
    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;
    logic [VAL_W-1:0]  value;
  } cmd_t;

  // index of the highest set bit, zero for zero
  function automatic logic [LVL_W-1:0] floor_log2(input logic [CNT_W-1:0] x);
    logic [LVL_W-1:0] k;
    k = '0;
    for (int i = 0; i < CNT_W; i++) begin
      if (x[i]) k = LVL_W'(i);
    end
    return k;
  endfunction

endpackage
`default_nettype wire

/* src/sparse_table_range_min_max.sv */
// a query is popped from the queue and its two table words are read into registers, then the
// min/max merge is registered into the result register behind out_tvalid; a bad interval
// skips the table read, and the next query is popped only once the last result is registered
// a load is a single table write; a build of count n fills levels 1 to floor(log2 n) in turn,
// one table entry per cycle, while later beats wait in the 4-deep queue
// reset: synchronous active-low; queue and result register empty, count set to 1
`default_nettype none
module sparse_table_range_min_max import strmm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,    // position, value, left_index, right_index, pad
  input  wire logic [1:0]  in_tuser,    // req_type
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,   // range_min, range_max
  output logic             out_tuser,   // status
  input  wire logic        cfg_wr_en,
  input  wire logic [10:0] cfg_wr_data  // active_count
);

  logic [CNT_W-1:0] active_count_r;
  logic [CNT_W-1:0] eff_count;
  logic             q_push;
  cmd_t             q_push_cmd;
  logic             q_full;
  logic             q_pop;
  logic             q_valid;
  cmd_t             q_head;

  // count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_count_r <= CNT_W'(1);
    end else if (cfg_wr_en) begin
      active_count_r <= cfg_wr_data;
    end
  end

  // clamp to the table size
  assign eff_count = (active_count_r > CNT_W'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES)
                                                            : active_count_r;

  strmm_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .count     (eff_count),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_push_cmd)
  );

  strmm_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (q_push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head_cmd  (q_head)
  );

  strmm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .count      (eff_count),
    .q_valid    (q_valid),
    .q_cmd      (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire

/* src/strmm_front.sv */
// front end: takes input beats, drops unused kinds, decodes queries into table addresses
// depends on strmm_pkg
`default_nettype none
module strmm_front import strmm_pkg::*; (
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [63:0]      in_tdata,   // position, value, left_index, right_index, pad
  input  wire logic [1:0]       in_tuser,   // req_type
  input  wire logic [CNT_W-1:0] count,
  input  wire logic             q_full,
  output logic                  q_push,
  output cmd_t                  q_cmd
);

  logic [POS_W-1:0] pos;
  logic [VAL_W-1:0] val;
  logic [POS_W-1:0] left_idx;
  logic [POS_W-1:0] right_idx;
  logic [CNT_W-1:0] span_len;
  logic [LVL_W-1:0] span_lvl;
  logic [CNT_W-1:0] span_pow;
  logic [CNT_W-1:0] b_pos;
  logic             kind_ok;

  // unpack the beat
  assign pos       = in_tdata[9:0];
  assign val       = in_tdata[41:10];
  assign left_idx  = in_tdata[51:42];
  assign right_idx = in_tdata[61:52];

  assign in_tready = !q_full;

  // two overlapping power-of-two spans cover the range
  assign span_len = {1'b0, right_idx} - {1'b0, left_idx} + CNT_W'(1);
  assign span_lvl = floor_log2(span_len);
  assign span_pow = CNT_W'(1) << span_lvl;
  assign b_pos    = {1'b0, right_idx} + CNT_W'(1) - span_pow;

  // classify the request
  always_comb begin
    kind_ok      = 1'b0;
    q_cmd.op     = REQ_LOAD;
    q_cmd.bad    = 1'b0;
    q_cmd.addr_a = {{LVL_W{1'b0}}, pos};
    q_cmd.addr_b = {{LVL_W{1'b0}}, pos};
    q_cmd.value  = val;
    case (in_tuser)
      REQ_LOAD: begin
        kind_ok  = 1'b1;
        q_cmd.op = REQ_LOAD;
      end
      REQ_BUILD: begin
        kind_ok  = 1'b1;
        q_cmd.op = REQ_BUILD;
      end
      REQ_QUERY: begin
        kind_ok      = 1'b1;
        q_cmd.op     = REQ_QUERY;
        q_cmd.bad    = (left_idx > right_idx) || ({1'b0, right_idx} >= count);
        q_cmd.addr_a = {span_lvl, left_idx};
        q_cmd.addr_b = {span_lvl, b_pos[POS_W-1:0]};
      end
      default: begin
        kind_ok = 1'b0;
      end
    endcase
  end

  assign q_push = in_tvalid && in_tready && kind_ok;

endmodule
`default_nettype wire

/* src/strmm_fifo.sv */
// short command queue between front and back ends
// depends on strmm_pkg
`default_nettype none
module strmm_fifo import strmm_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      full,
  input  wire logic pop,
  output logic      not_empty,
  output cmd_t      head_cmd
);

  cmd_t              slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   fill_r, fill_nxt;
  logic              do_push;
  logic              do_pop;

  assign full      = (fill_r == (QPTR_W+1)'(QDEPTH));
  assign not_empty = (fill_r != '0);
  assign head_cmd  = slot_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  // pointer and fill update
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    fill_nxt   = fill_r + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // storage, no reset
  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_cmd;
  end

endmodule
`default_nettype wire

/* src/strmm_back.sv */
// back end: table memory, load writes, level build sequencer, query read and result register
// depends on strmm_pkg
`default_nettype none
module strmm_back import strmm_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [CNT_W-1:0] count,
  input  wire logic             q_valid,
  input  wire cmd_t             q_cmd,
  output logic                  q_pop,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic [63:0]           out_tdata,  // range_min, range_max
  output logic                  out_tuser   // status
);

  // table: max in the upper half, min in the lower half of each word
  logic [2*VAL_W-1:0] mem [DEPTH];
  logic [2*VAL_W-1:0] rd_a_r, rd_b_r;
  logic [ADDR_W-1:0]  rd_addr_a, rd_addr_b;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [2*VAL_W-1:0] mem_wdata;

  back_state_t        state_r, state_nxt;
  logic [LVL_W-1:0]   lvl_r, lvl_nxt;
  logic [POS_W-1:0]   j_r, j_nxt;
  logic               wr_pend_r, wr_pend_nxt;
  logic [ADDR_W-1:0]  wr_addr_r, wr_addr_nxt;
  logic               pair_r, pair_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0]   out_min_r, out_min_nxt;
  logic [VAL_W-1:0]   out_max_r, out_max_nxt;
  logic               out_stat_r, out_stat_nxt;

  logic [LVL_W-1:0]   top_lvl;
  logic [LVL_W-1:0]   lvl_m1;
  logic [CNT_W-1:0]   half;
  logic [CNT_W-1:0]   j_half;
  logic               pair_now;
  logic               last_j;
  logic               slot_free;
  logic               use_b;
  logic [VAL_W-1:0]   mrg_min, mrg_max;

  assign top_lvl   = floor_log2(count);
  assign lvl_m1    = lvl_r - LVL_W'(1);
  assign half      = CNT_W'(1) << lvl_m1;
  assign j_half    = {1'b0, j_r} + half;
  assign pair_now  = (j_half < count);
  assign last_j    = ({1'b0, j_r} == count - CNT_W'(1));
  assign slot_free = !out_valid_r || out_tready;

  // shared min/max merge of the two registered read words
  assign use_b   = (state_r == BK_QUERY) || pair_r;
  assign mrg_min = (use_b && ($signed(rd_b_r[VAL_W-1:0]) < $signed(rd_a_r[VAL_W-1:0])))
                   ? rd_b_r[VAL_W-1:0] : rd_a_r[VAL_W-1:0];
  assign mrg_max = (use_b && ($signed(rd_a_r[2*VAL_W-1:VAL_W]) <
                              $signed(rd_b_r[2*VAL_W-1:VAL_W])))
                   ? rd_b_r[2*VAL_W-1:VAL_W] : rd_a_r[2*VAL_W-1:VAL_W];

  // next state and counters
  always_comb begin
    state_nxt     = state_r;
    lvl_nxt       = lvl_r;
    j_nxt         = j_r;
    wr_pend_nxt   = 1'b0;
    wr_addr_nxt   = wr_addr_r;
    pair_nxt      = pair_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_min_nxt   = out_min_r;
    out_max_nxt   = out_max_r;
    out_stat_nxt  = out_stat_r;
    case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          case (q_cmd.op)
            REQ_BUILD: begin
              if (top_lvl != '0) begin
                state_nxt = BK_BUILD;
                lvl_nxt   = LVL_W'(1);
                j_nxt     = '0;
              end
            end
            REQ_QUERY: begin
              if (slot_free) begin
                if (q_cmd.bad) begin
                  out_valid_nxt = 1'b1;
                  out_min_nxt   = '0;
                  out_max_nxt   = '0;
                  out_stat_nxt  = 1'b1;
                end else begin
                  state_nxt = BK_QUERY;
                end
              end
            end
            default: begin
              state_nxt = BK_IDLE;
            end
          endcase
        end
      end
      BK_QUERY: begin
        out_valid_nxt = 1'b1;
        out_min_nxt   = mrg_min;
        out_max_nxt   = mrg_max;
        out_stat_nxt  = 1'b0;
        state_nxt     = BK_IDLE;
      end
      BK_BUILD: begin
        wr_pend_nxt = 1'b1;
        wr_addr_nxt = {lvl_r, j_r};
        pair_nxt    = pair_now;
        if (last_j) begin
          state_nxt = BK_DRAIN;
        end else begin
          j_nxt = j_r + POS_W'(1);
        end
      end
      BK_DRAIN: begin
        if (lvl_r == top_lvl) begin
          state_nxt = BK_IDLE;
        end else begin
          state_nxt = BK_BUILD;
          lvl_nxt   = lvl_r + LVL_W'(1);
          j_nxt     = '0;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  // queue pop and memory port controls
  always_comb begin
    q_pop     = 1'b0;
    rd_addr_a = q_cmd.addr_a;
    rd_addr_b = q_cmd.addr_b;
    mem_we    = wr_pend_r;
    mem_waddr = wr_addr_r;
    mem_wdata = {mrg_max, mrg_min};
    case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          case (q_cmd.op)
            REQ_LOAD: begin
              q_pop     = 1'b1;
              mem_we    = 1'b1;
              mem_waddr = q_cmd.addr_a;
              mem_wdata = {q_cmd.value, q_cmd.value};
            end
            REQ_BUILD: begin
              q_pop = 1'b1;
            end
            REQ_QUERY: begin
              q_pop = slot_free;
            end
            default: begin
              q_pop = 1'b1;
            end
          endcase
        end
      end
      BK_BUILD: begin
        rd_addr_a = {lvl_m1, j_r};
        rd_addr_b = {lvl_m1, j_half[POS_W-1:0]};
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      wr_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wr_pend_r   <= wr_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    lvl_r      <= lvl_nxt;
    j_r        <= j_nxt;
    wr_addr_r  <= wr_addr_nxt;
    pair_r     <= pair_nxt;
    out_min_r  <= out_min_nxt;
    out_max_r  <= out_max_nxt;
    out_stat_r <= out_stat_nxt;
  end

  // table memory, one write and two registered reads
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_a_r <= mem[rd_addr_a];
    rd_b_r <= mem[rd_addr_b];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_max_r, out_min_r};
  assign out_tuser  = out_stat_r;

endmodule
`default_nettype wire

/* src/strmm_checker.sv */
// port-level checks for the sparse-table range min/max engine, bound to the top level
// depends on the top level's port list only
`default_nettype none
module strmm_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [63:0] out_tdata,
  input wire logic        out_tuser
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // a bad interval reports zeros
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == 64'd0)
    else $error("bad interval with nonzero data");

  // reset empties the result register
  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // reset empties the queue, so input is ready
  a_rst_in: assert property (@(posedge clk) !rst_n |=> in_tready)
    else $error("input not ready after reset");

endmodule

bind sparse_table_range_min_max strmm_checker u_chk (.*);
`default_nettype wire
